@@ sv/s2hb_pkg.sv @@
// ============================================================================
// s2hb_pkg - shared types and constants for the symmetric 2D histogram binner
// Request and result layouts, configuration register map, queue entry type
// and the saturating accumulate used on the bin store.
// ============================================================================
`default_nettype none

package s2hb_pkg;

    // Field widths fixed by the request and result formats
    localparam int FREQ_W     = 32;
    localparam int AMP_W      = 32;
    localparam int ACC_W      = 48;
    localparam int BUS_IDX_W  = 8;
    localparam int MAXF_W     = 31;
    localparam int SCALE_W    = 32;
    localparam int NPTS_W     = 9;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FREQ  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIN_SCALE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_N_POINTS  = 2'd2;

    localparam logic [MAXF_W-1:0]  MAX_FREQ_RST  = 31'd65536;
    localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 32'd65536;
    localparam logic [NPTS_W-1:0]  N_POINTS_RST  = 9'd256;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_POINTS = 256;
    localparam int QUEUE_DEPTH    = 4;

    // Request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Operation handed from the front end to the store
    typedef enum logic [1:0] {
        OP_ZERO,
        OP_ADD,
        OP_READ,
        OP_WRITE
    } op_t;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic signed [FREQ_W-1:0]    freq_a;
        logic signed [FREQ_W-1:0]    freq_b;
        logic signed [AMP_W-1:0]     amp_re;
        logic signed [AMP_W-1:0]     amp_im;
        logic [BUS_IDX_W-1:0]        bin_row;
        logic [BUS_IDX_W-1:0]        bin_col;
    } in_item_t;

    typedef struct packed {
        logic                        landed;
        logic signed [ACC_W-1:0]     read_re;
        logic signed [ACC_W-1:0]     read_im;
    } out_item_t;

    typedef struct packed {
        logic [MAXF_W-1:0]           max_freq;
        logic [SCALE_W-1:0]          bin_scale;
        logic [NPTS_W-1:0]           n_points;
    } cfg_t;

    // Fixed part of a queue entry; the two bin indices travel beside it
    typedef struct packed {
        op_t                         op;
        logic signed [AMP_W-1:0]     re;
        logic signed [AMP_W-1:0]     im;
    } entry_t;

    // Add a 32-bit amplitude to a 48-bit accumulator, clamp to the 48-bit range
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [AMP_W-1:0] add);
        logic [ACC_W:0] s;
        logic [ACC_W-1:0] r;
        s = {acc[ACC_W-1], acc} + {{(ACC_W-AMP_W+1){add[AMP_W-1]}}, add};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] sext_amp(input logic [AMP_W-1:0] v);
        return {{(ACC_W-AMP_W){v[AMP_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

@@ sv/s2hb_front.sv @@
// ============================================================================
// s2hb_front - request intake and bin classification
// Two-stage pipeline: offset both frequencies, scale them to bin indices,
// then range-check and push one decoded operation into the queue.
// ============================================================================
`default_nettype none

module s2hb_front #(
    parameter int MAX_POINTS = s2hb_pkg::DEF_MAX_POINTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire s2hb_pkg::cfg_t     cfg,
    input  wire logic               clearing,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire s2hb_pkg::in_item_t in_data,
    output logic                    q_push,
    input  wire logic               q_full,
    output s2hb_pkg::entry_t        q_entry,
    output logic [$clog2(MAX_POINTS)-1:0] q_idx_a,
    output logic [$clog2(MAX_POINTS)-1:0] q_idx_b
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CW    = IDX_W + s2hb_pkg::BUS_IDX_W + 1;
    localparam int SUM_W = s2hb_pkg::FREQ_W + 1;
    localparam int PROD_W = 2 * s2hb_pkg::SCALE_W;

    logic                     s0_valid_reg;
    s2hb_pkg::in_item_t       s0_item_reg;
    logic [SUM_W-1:0]         s0_sum_a_reg;
    logic [SUM_W-1:0]         s0_sum_b_reg;

    logic                     s1_valid_reg;
    s2hb_pkg::in_item_t       s1_item_reg;
    logic                     s1_neg_a_reg;
    logic                     s1_neg_b_reg;
    logic [PROD_W-1:0]        s1_prod_a_reg;
    logic [PROD_W-1:0]        s1_prod_b_reg;

    logic                     accept;
    logic                     s0_adv;
    logic                     s1_adv;
    logic [SUM_W-1:0]         sum_a;
    logic [SUM_W-1:0]         sum_b;
    logic [PROD_W-1:0]        prod_a;
    logic [PROD_W-1:0]        prod_b;
    logic [s2hb_pkg::SCALE_W-1:0] k_a;
    logic [s2hb_pkg::SCALE_W-1:0] k_b;
    logic [s2hb_pkg::SCALE_W-1:0] lim;
    logic                     ok_a;
    logic                     ok_b;
    logic [CW-1:0]            row_ext;
    logic [CW-1:0]            col_ext;
    logic                     bus_ok;

    // Pipeline flow: stage 1 drains into the queue, stage 0 into stage 1
    assign q_push   = s1_valid_reg && !q_full;
    assign s1_adv   = !s1_valid_reg || q_push;
    assign s0_adv   = !s0_valid_reg || s1_adv;
    assign accept   = in_valid && s0_adv && !clearing;
    assign in_stall = !s0_adv || clearing;

    // Offset each frequency by the half span
    assign sum_a = {in_data.freq_a[s2hb_pkg::FREQ_W-1], in_data.freq_a}
                 + SUM_W'(cfg.max_freq);
    assign sum_b = {in_data.freq_b[s2hb_pkg::FREQ_W-1], in_data.freq_b}
                 + SUM_W'(cfg.max_freq);

    // Scale: non-negative sums fit 32 bits, a negative one is handled by its sign
    assign prod_a = PROD_W'(s0_sum_a_reg[SUM_W-2:0]) * PROD_W'(cfg.bin_scale);
    assign prod_b = PROD_W'(s0_sum_b_reg[SUM_W-2:0]) * PROD_W'(cfg.bin_scale);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else begin
            if (s0_adv) begin
                s0_valid_reg <= accept;
            end
            if (s1_adv) begin
                s1_valid_reg <= s0_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        if (accept) begin
            s0_item_reg  <= in_data;
            s0_sum_a_reg <= sum_a;
            s0_sum_b_reg <= sum_b;
        end
        if (s1_adv && s0_valid_reg) begin
            s1_item_reg   <= s0_item_reg;
            s1_neg_a_reg  <= s0_sum_a_reg[SUM_W-1];
            s1_neg_b_reg  <= s0_sum_b_reg[SUM_W-1];
            s1_prod_a_reg <= prod_a;
            s1_prod_b_reg <= prod_b;
        end
    end

    // Floor to bin index and check against the active side length
    assign k_a = s1_prod_a_reg[PROD_W-1:s2hb_pkg::SCALE_W];
    assign k_b = s1_prod_b_reg[PROD_W-1:s2hb_pkg::SCALE_W];
    assign lim = (s2hb_pkg::SCALE_W'(cfg.n_points) > s2hb_pkg::SCALE_W'(MAX_POINTS))
               ? s2hb_pkg::SCALE_W'(MAX_POINTS) : s2hb_pkg::SCALE_W'(cfg.n_points);
    assign ok_a = !(s1_neg_a_reg && (cfg.bin_scale != '0)) && (k_a < lim);
    assign ok_b = !(s1_neg_b_reg && (cfg.bin_scale != '0)) && (k_b < lim);

    // Bus addresses must lie inside the store
    assign row_ext = CW'(s1_item_reg.bin_row);
    assign col_ext = CW'(s1_item_reg.bin_col);
    assign bus_ok  = (row_ext < CW'(MAX_POINTS)) && (col_ext < CW'(MAX_POINTS));

    // Decode the request into a store operation
    always_comb begin
        q_entry.re = s1_item_reg.amp_re;
        q_entry.im = s1_item_reg.amp_im;
        q_idx_a    = row_ext[IDX_W-1:0];
        q_idx_b    = col_ext[IDX_W-1:0];
        unique case (s1_item_reg.req_type)
            s2hb_pkg::REQ_ADD: begin
                q_entry.op = (ok_a && ok_b) ? s2hb_pkg::OP_ADD : s2hb_pkg::OP_ZERO;
                q_idx_a    = k_a[IDX_W-1:0];
                q_idx_b    = k_b[IDX_W-1:0];
            end
            s2hb_pkg::REQ_READ: begin
                q_entry.op = bus_ok ? s2hb_pkg::OP_READ : s2hb_pkg::OP_ZERO;
            end
            s2hb_pkg::REQ_WRITE: begin
                q_entry.op = bus_ok ? s2hb_pkg::OP_WRITE : s2hb_pkg::OP_ZERO;
            end
            default: begin
                q_entry.op = s2hb_pkg::OP_ZERO;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/s2hb_queue.sv @@
// ============================================================================
// s2hb_queue - short FIFO between classification and the bin store
// Register-based ring buffer with fill count; head is visible while not empty.
// ============================================================================
`default_nettype none

module s2hb_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = s2hb_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/s2hb_back.sv @@
// ============================================================================
// s2hb_back - bin store and read-modify-write engine
// Issues one store access per cycle from the queue head (two per add) unless
// clearing or a stalled result holds it; updates in the execute stage, with
// write forwarding; result in an output register. Clears the store after reset.
// ============================================================================
`default_nettype none

module s2hb_back #(
    parameter int MAX_POINTS = s2hb_pkg::DEF_MAX_POINTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire s2hb_pkg::entry_t            head,
    input  wire logic [$clog2(MAX_POINTS)-1:0] head_idx_a,
    input  wire logic [$clog2(MAX_POINTS)-1:0] head_idx_b,
    input  wire logic                        head_empty,
    output logic                             pop,
    output logic                             clearing,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output s2hb_pkg::out_item_t              out_data
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int ACC_W  = s2hb_pkg::ACC_W;
    localparam int WORD_W = 2 * ACC_W;

    // Bin store: real part in the upper half, imaginary in the lower half
    logic [WORD_W-1:0] mem [MEM_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic              phase_reg;

    logic              ex_valid_reg;
    s2hb_pkg::op_t     ex_op_reg;
    logic              ex_last_reg;
    logic [s2hb_pkg::AMP_W-1:0] ex_re_reg;
    logic [s2hb_pkg::AMP_W-1:0] ex_im_reg;
    logic [ADDR_W-1:0] ex_addr_reg;

    logic              out_valid_reg;
    s2hb_pkg::out_item_t out_data_reg;

    logic              issue_last;
    logic              issue_fire;
    logic [ADDR_W-1:0] issue_addr;
    logic              ex_fire;
    logic [WORD_W-1:0] cur;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              ex_wr;
    logic [WORD_W-1:0] ex_wr_data;
    s2hb_pkg::out_item_t res;

    assign clearing  = clr_active_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Issue: an add reads (a,b) then (b,a); other operations take one slot
    assign issue_last = (head.op != s2hb_pkg::OP_ADD) || phase_reg;
    assign issue_addr = phase_reg ? {head_idx_b, head_idx_a} : {head_idx_a, head_idx_b};
    assign ex_fire    = ex_valid_reg && (!ex_last_reg || !out_valid_reg || !out_stall);
    assign issue_fire = !head_empty && !clr_active_reg && (!ex_valid_reg || ex_fire);
    assign pop        = issue_fire && issue_last;

    // Current bin value, with a write made in the issue cycle forwarded
    assign cur = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    // Execute the update and form the result
    always_comb begin
        ex_wr      = 1'b0;
        ex_wr_data = cur;
        res        = '0;
        unique case (ex_op_reg)
            s2hb_pkg::OP_ADD: begin
                ex_wr      = 1'b1;
                ex_wr_data = {s2hb_pkg::sat_add(cur[WORD_W-1:ACC_W], ex_re_reg),
                              s2hb_pkg::sat_add(cur[ACC_W-1:0], ex_im_reg)};
                res.landed = 1'b1;
            end
            s2hb_pkg::OP_WRITE: begin
                ex_wr      = 1'b1;
                ex_wr_data = {s2hb_pkg::sext_amp(ex_re_reg), s2hb_pkg::sext_amp(ex_im_reg)};
            end
            s2hb_pkg::OP_READ: begin
                res.read_re = cur[WORD_W-1:ACC_W];
                res.read_im = cur[ACC_W-1:0];
            end
            s2hb_pkg::OP_ZERO: begin
                ex_wr = 1'b0;
            end
            default: begin
                ex_wr = 1'b0;
            end
        endcase
    end

    // Write port: clearing pass first, then the execute stage
    assign wr_en   = clr_active_reg || (ex_fire && ex_wr);
    assign wr_addr = clr_active_reg ? clr_cnt_reg : ex_addr_reg;
    assign wr_data = clr_active_reg ? '0 : ex_wr_data;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue_fire) begin
            rd_data_reg  <= mem[issue_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Control: clearing pass, issue phase, execute stage and output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            phase_reg      <= 1'b0;
            ex_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (clr_active_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_W{1'b1}}) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (issue_fire) begin
                phase_reg    <= !issue_last;
                ex_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (wr_addr == issue_addr);
            end
            else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire && ex_last_reg) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the execute stage and the output
    always_ff @(posedge clk) begin
        if (issue_fire) begin
            ex_op_reg   <= head.op;
            ex_last_reg <= issue_last;
            ex_re_reg   <= head.re;
            ex_im_reg   <= head.im;
            ex_addr_reg <= issue_addr;
        end
        if (ex_fire && ex_last_reg) begin
            out_data_reg <= res;
        end
    end

    // A held execute stage keeps its read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && !ex_fire) |=> ($stable(rd_data_reg) && $stable(fwd_hit_reg)))
        else $error("store read data changed under a held execute stage");

    // The second half of an add only runs while that add is still at the head
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!head_empty && (head.op == s2hb_pkg::OP_ADD)))
        else $error("second add access without an add at the queue head");

    // The clearing pass ends only after the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> ($past(clr_cnt_reg) == {ADDR_W{1'b1}}))
        else $error("clearing pass ended early");

    // The clearing pass runs once per reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

@@ sv/symmetric_2d_histogram_binner.sv @@
// ============================================================================
// symmetric_2d_histogram_binner - complex 2D spectrum peak accumulator
// Bins (freq_a, freq_b) peaks into a square complex store, adding the
// amplitude at (a,b) and at (b,a) with saturation; bus reads and writes of
// single bins for preload and readout.
// ============================================================================
//
//  channel  | signals                          | direction | transfer
//  ---------+----------------------------------+-----------+---------------------------
//  request  | in_valid, in_stall, in_data      | in        | in_valid && !in_stall
//  result   | out_valid, out_stall, out_data   | out       | out_valid && !out_stall
//  config   | cfg_we, cfg_addr, cfg_wdata      | in        | cfg_we
//
//  An add that lands takes two accesses of the single-write-port bin store
//  (one read-modify-write per mirrored bin); reads, writes and dropped adds
//  take one. Requests enter at one per cycle until the queue fills, and not
//  during the clearing pass. A request passes the front stage registers, the
//  queue, the execute stage and the output register before out_valid rises.
//  After reset the store's 2**(2*ceil(log2(MAX_POINTS))) entries, 65536 at
//  the default, are cleared one entry per cycle; in_stall is high while they
//  are cleared. A stalled result register does not block intake until the
//  queue is full.
// ============================================================================
`default_nettype none

module symmetric_2d_histogram_binner #(
    parameter int MAX_POINTS = s2hb_pkg::DEF_MAX_POINTS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire s2hb_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output s2hb_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_we,
    input  wire logic [s2hb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [s2hb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int ENT_W = $bits(s2hb_pkg::entry_t);
    localparam int Q_W   = ENT_W + 2 * IDX_W;

    logic [s2hb_pkg::MAXF_W-1:0]  max_freq_reg;
    logic [s2hb_pkg::SCALE_W-1:0] bin_scale_reg;
    logic [s2hb_pkg::NPTS_W-1:0]  n_points_reg;
    s2hb_pkg::cfg_t               cfg;

    logic                 clearing;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    s2hb_pkg::entry_t     f_entry;
    logic [IDX_W-1:0]     f_idx_a;
    logic [IDX_W-1:0]     f_idx_b;
    logic [Q_W-1:0]       q_wdata;
    logic [Q_W-1:0]       q_rdata;
    s2hb_pkg::entry_t     h_entry;
    logic [IDX_W-1:0]     h_idx_a;
    logic [IDX_W-1:0]     h_idx_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_freq_reg  <= s2hb_pkg::MAX_FREQ_RST;
            bin_scale_reg <= s2hb_pkg::BIN_SCALE_RST;
            n_points_reg  <= s2hb_pkg::N_POINTS_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_addr)
                s2hb_pkg::CFG_MAX_FREQ:  max_freq_reg  <= cfg_wdata[s2hb_pkg::MAXF_W-1:0];
                s2hb_pkg::CFG_BIN_SCALE: bin_scale_reg <= cfg_wdata[s2hb_pkg::SCALE_W-1:0];
                s2hb_pkg::CFG_N_POINTS:  n_points_reg  <= cfg_wdata[s2hb_pkg::NPTS_W-1:0];
                default: begin
                    max_freq_reg <= max_freq_reg;
                end
            endcase
        end
    end

    assign cfg.max_freq  = max_freq_reg;
    assign cfg.bin_scale = bin_scale_reg;
    assign cfg.n_points  = n_points_reg;

    s2hb_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .clearing (clearing),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_entry  (f_entry),
        .q_idx_a  (f_idx_a),
        .q_idx_b  (f_idx_b)
    );

    // Pack and unpack queue entries
    assign q_wdata = {f_entry, f_idx_a, f_idx_b};
    assign h_entry = q_rdata[Q_W-1:2*IDX_W];
    assign h_idx_a = q_rdata[2*IDX_W-1:IDX_W];
    assign h_idx_b = q_rdata[IDX_W-1:0];

    s2hb_queue #(
        .WIDTH (Q_W),
        .DEPTH (s2hb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    s2hb_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (h_entry),
        .head_idx_a (h_idx_a),
        .head_idx_b (h_idx_b),
        .head_empty (q_empty),
        .pop        (q_pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
